### rtl/cmsf_pkg.sv
// Shared types and constants for the count-min sketch flagger.
// Used by cmsf_hash, cmsf_count and the top level; depends on nothing.
package cmsf_pkg;

  localparam int unsigned KEY_W       = 38;
  localparam int unsigned EST_W       = 32;
  localparam int unsigned THR_W       = 32;
  localparam int unsigned MULT_W      = 26;
  localparam int unsigned MULT_REGS   = 4;
  localparam int unsigned MULT_SEL_W  = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_MULT_ROW0 = 3'd1,
    CFG_MULT_ROW1 = 3'd2,
    CFG_MULT_ROW2 = 3'd3,
    CFG_MULT_ROW3 = 3'd4
  } cfg_idx_e;

  typedef logic [MULT_REGS-1:0][MULT_W-1:0] mult_arr_t;

  // key_echo sits in the low bits
  typedef struct packed {
    logic             any_flagged;
    logic             flagged;
    logic [EST_W-1:0] estimate;
    logic [KEY_W-1:0] key_echo;
  } result_t;

endpackage

### rtl/cmsf_hash.sv
// Front end: reduces each key to one counter index per row.
// Pipelined (key mod depth), then (key mod depth) * multiplier, then mod depth again.
// Depends on cmsf_pkg.
module cmsf_hash #(
  parameter int unsigned NUM_ROWS  = 4,
  parameter int unsigned ROW_DEPTH = 1024,
  parameter int unsigned IDX_W     = $clog2(ROW_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cmsf_pkg::KEY_W-1:0]    in_key_i,
  input  cmsf_pkg::mult_arr_t           mult_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cmsf_pkg::KEY_W-1:0]    out_key_o,
  output logic [NUM_ROWS*IDX_W-1:0]     out_idx_o
);

  localparam int unsigned KD     = (cmsf_pkg::KEY_W + 3) / 4;
  localparam int unsigned KP_W   = KD * 4;
  localparam int unsigned PROD_W = IDX_W + cmsf_pkg::MULT_W;
  localparam int unsigned PD     = (PROD_W + 3) / 4;
  localparam int unsigned PP_W   = PD * 4;
  localparam logic [IDX_W+3:0] DIV_W = (IDX_W+4)'(ROW_DEPTH);

  // One radix-16 digit of a remainder: (rem*16 + dig) mod depth, restoring style.
  function automatic logic [IDX_W-1:0] mod_step(input logic [IDX_W-1:0] rem,
                                                input logic [3:0]       dig);
    logic [IDX_W+3:0] v;
    v = {rem, dig};
    for (int j = 3; j >= 0; j--) begin
      if (v >= (DIV_W << j)) begin
        v = v - (DIV_W << j);
      end
    end
    return v[IDX_W-1:0];
  endfunction

  logic                        adv;
  logic [KP_W-1:0]             in_pad;

  logic [KD-1:0]               kv_q;
  logic [cmsf_pkg::KEY_W-1:0]  kkey_q [KD];
  logic [IDX_W-1:0]            krem_q [KD];

  logic                        mv_q;
  logic [cmsf_pkg::KEY_W-1:0]  mkey_q;
  logic [PROD_W-1:0]           prod_c  [NUM_ROWS];
  logic [PP_W-1:0]             mprod_q [NUM_ROWS];

  logic [PD-1:0]               pv_q;
  logic [cmsf_pkg::KEY_W-1:0]  pkey_q  [PD];
  logic [IDX_W-1:0]            prem_q  [PD][NUM_ROWS];
  logic [PP_W-1:0]             pprod_q [PD-1][NUM_ROWS];

  assign adv        = !pv_q[PD-1] || out_ready_i;
  assign in_ready_o = adv;
  assign in_pad     = {{(KP_W - cmsf_pkg::KEY_W){1'b0}}, in_key_i};

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      prod_c[r] = PROD_W'(krem_q[KD-1]) * PROD_W'(mult_i[r % cmsf_pkg::MULT_REGS]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kv_q <= '0;
      mv_q <= 1'b0;
      pv_q <= '0;
    end else if (adv) begin
      kv_q <= {kv_q[KD-2:0], in_valid_i};
      mv_q <= kv_q[KD-1];
      pv_q <= {pv_q[PD-2:0], mv_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // key digits, most significant first
      kkey_q[0] <= in_key_i;
      krem_q[0] <= mod_step('0, in_pad[(KD-1)*4 +: 4]);
      for (int s = 1; s < KD; s++) begin
        kkey_q[s] <= kkey_q[s-1];
        krem_q[s] <= mod_step(krem_q[s-1], kkey_q[s-1][(KD-1-s)*4 +: 4]);
      end

      mkey_q <= kkey_q[KD-1];
      for (int r = 0; r < NUM_ROWS; r++) begin
        mprod_q[r] <= PP_W'(prod_c[r]);
      end

      // product digits per row
      pkey_q[0] <= mkey_q;
      for (int r = 0; r < NUM_ROWS; r++) begin
        prem_q[0][r]  <= mod_step('0, mprod_q[r][(PD-1)*4 +: 4]);
        pprod_q[0][r] <= mprod_q[r];
      end
      for (int t = 1; t < PD; t++) begin
        pkey_q[t] <= pkey_q[t-1];
        for (int r = 0; r < NUM_ROWS; r++) begin
          prem_q[t][r] <= mod_step(prem_q[t-1][r], pprod_q[t-1][r][(PD-1-t)*4 +: 4]);
        end
      end
      for (int t = 1; t < PD - 1; t++) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
          pprod_q[t][r] <= pprod_q[t-1][r];
        end
      end
    end
  end

  assign out_valid_o = pv_q[PD-1];
  assign out_key_o   = pkey_q[PD-1];

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      out_idx_o[r*IDX_W +: IDX_W] = prem_q[PD-1][r];
    end
  end

endmodule

### rtl/cmsf_queue.sv
// Short FIFO between the hash front end and the counter back end.
// Register array with head/tail pointers; depends on nothing else.
module cmsf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PW:0]      cnt_q;
  logic             do_push, do_pop;

  assign ready_o = cnt_q != (PW+1)'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(DEPTH))
    else $error("queue fill count above depth");

endmodule

### rtl/cmsf_count.sv
// Back end: per-row counter memories, read-modify-write with forwarding,
// min over rows, threshold check and sticky flag. Also runs the clear pass.
// Depends on cmsf_pkg.
module cmsf_count #(
  parameter int unsigned NUM_ROWS   = 4,
  parameter int unsigned ROW_DEPTH  = 1024,
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned IDX_W      = $clog2(ROW_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cmsf_pkg::THR_W-1:0]    threshold_i,
  input  logic                          q_valid_i,
  input  logic [cmsf_pkg::KEY_W-1:0]    q_key_i,
  input  logic [NUM_ROWS*IDX_W-1:0]     q_idx_i,
  output logic                          q_pop_o,
  output logic                          clear_busy_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output cmsf_pkg::result_t             res_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic                         adv, item_wr;
  logic                         clr_busy_q;
  logic [IDX_W-1:0]             clr_addr_q;

  logic                         v1_q;
  logic [cmsf_pkg::KEY_W-1:0]   key1_q;
  logic [IDX_W-1:0]             idx1_q [NUM_ROWS];
  logic [COUNT_BITS-1:0]        rd_q   [NUM_ROWS];

  logic                         lw_v_q;
  logic [IDX_W-1:0]             lw_addr_q [NUM_ROWS];
  logic [COUNT_BITS-1:0]        lw_data_q [NUM_ROWS];

  logic [COUNT_BITS-1:0]        cur_c [NUM_ROWS];
  logic [COUNT_BITS-1:0]        new_c [NUM_ROWS];

  logic                         v2_q;
  logic [cmsf_pkg::KEY_W-1:0]   key2_q;
  logic [COUNT_BITS-1:0]        cnt2_q [NUM_ROWS];

  logic                         res_valid_q;
  cmsf_pkg::result_t            res_q;
  logic                         seen_q;

  logic [COUNT_BITS-1:0]        min_c;
  logic [cmsf_pkg::EST_W-1:0]   est_c;
  logic                         flag_c;

  assign adv          = !res_valid_q || res_ready_i;
  assign q_pop_o      = adv && !clr_busy_q;
  assign item_wr      = adv && v1_q;
  assign clear_busy_o = clr_busy_q;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  // Read data is registered behind the address; the last write covers the one
  // update the memory read could have missed.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      cur_c[r] = (lw_v_q && lw_addr_q[r] == idx1_q[r]) ? lw_data_q[r] : rd_q[r];
      new_c[r] = (cur_c[r] == CNT_MAX) ? cur_c[r] : cur_c[r] + 1'b1;
    end
  end

  always_comb begin
    min_c = cnt2_q[0];
    for (int r = 1; r < NUM_ROWS; r++) begin
      if (cnt2_q[r] < min_c) begin
        min_c = cnt2_q[r];
      end
    end
    est_c  = cmsf_pkg::EST_W'(min_c);
    flag_c = est_c >= threshold_i;
  end

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    logic [COUNT_BITS-1:0] mem [ROW_DEPTH];
    logic [IDX_W-1:0]      wa;
    logic [COUNT_BITS-1:0] wd;

    assign wa = clr_busy_q ? clr_addr_q : idx1_q[r];
    assign wd = clr_busy_q ? '0 : new_c[r];

    always_ff @(posedge clk_i) begin
      if (clr_busy_q || item_wr) begin
        mem[wa] <= wd;
      end
      if (adv) begin
        rd_q[r] <= mem[q_idx_i[r*IDX_W +: IDX_W]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      res_valid_q <= 1'b0;
      lw_v_q      <= 1'b0;
      seen_q      <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        if (clr_addr_q == IDX_W'(ROW_DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (adv) begin
        v1_q        <= q_valid_i && !clr_busy_q;
        v2_q        <= v1_q;
        res_valid_q <= v2_q;
        if (v2_q && flag_c) begin
          seen_q <= 1'b1;
        end
      end
      if (item_wr) begin
        lw_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      key1_q <= q_key_i;
      key2_q <= key1_q;
      for (int r = 0; r < NUM_ROWS; r++) begin
        idx1_q[r] <= q_idx_i[r*IDX_W +: IDX_W];
        cnt2_q[r] <= new_c[r];
      end
      res_q.key_echo    <= key2_q;
      res_q.estimate    <= est_c;
      res_q.flagged     <= flag_c;
      res_q.any_flagged <= seen_q || flag_c;
    end
    if (item_wr) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        lw_addr_q[r] <= idx1_q[r];
        lw_data_q[r] <= new_c[r];
      end
    end
  end

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$rose(clr_busy_q))
    else $error("clear pass restarted after reset");

  a_no_wr_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !v1_q && !v2_q)
    else $error("item in flight during clear pass");

  a_est_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_q.estimate != '0)
    else $error("estimate of an incremented counter is zero");

  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |=> seen_q)
    else $error("sticky flag dropped");

endmodule

### rtl/count_min_sketch_flagger_core.sv
// Top level of the count-min sketch flagger: config registers, hash front end,
// queue and counter back end. Depends on cmsf_pkg, cmsf_hash, cmsf_queue, cmsf_count.
//
// Channel   Dir  Handshake              Payload (low bit up)
// s_axis    in   tvalid/tready          tdata: addr_key[37:0], zero pad to 40
// m_axis    out  tvalid/tready          tdata: key_echo[37:0], estimate[69:38],
//                                              flagged[70], any_flagged[71]
// cfg       in   cfg_we_i, no wait      cfg_idx_i selects register, cfg_data_i
//
// One key per cycle sustained while m_axis_tready is high and no sweep runs. A key
// passes 11 + PD hash stages, 20 at defaults (PD = ceil((log2 ROW_DEPTH + 26)/4)),
// the queue and three counter stages. After reset the counter memories are swept to
// zero, one address of every row per cycle; s_axis_tready stays low until it ends.
// m_axis back-pressure freezes the counter pipeline; the queue accepts until full,
// and the hash pipeline until its last stage holds a key the full queue refuses.
module count_min_sketch_flagger_core #(
  parameter int unsigned NUM_ROWS   = 4,
  parameter int unsigned ROW_DEPTH  = 1024,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cmsf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // addr_key, pad
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cmsf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // key, est, flag, any
  input  logic                                cfg_we_i,
  input  logic [cmsf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cmsf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(ROW_DEPTH);
  localparam int unsigned Q_W   = cmsf_pkg::KEY_W + NUM_ROWS * IDX_W;

  logic [cmsf_pkg::THR_W-1:0]      thr_q;
  cmsf_pkg::mult_arr_t             mult_q;
  logic [cmsf_pkg::MULT_SEL_W-1:0] moff;

  logic                           clear_busy;
  logic                           f_in_ready;
  logic                           f_valid, f_ready;
  logic [cmsf_pkg::KEY_W-1:0]     f_key;
  logic [NUM_ROWS*IDX_W-1:0]      f_idx;

  logic                           q_valid, q_pop;
  logic [Q_W-1:0]                 q_data;

  logic                           res_valid;
  cmsf_pkg::result_t              res;

  assign moff = cmsf_pkg::MULT_SEL_W'(cfg_idx_i -
                                      cmsf_pkg::CFG_IDX_W'(cmsf_pkg::CFG_MULT_ROW0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      for (int i = 0; i < cmsf_pkg::MULT_REGS; i++) begin
        mult_q[i] <= cmsf_pkg::MULT_W'(1);
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i) inside
        cmsf_pkg::CFG_THRESHOLD: begin
          thr_q <= cfg_data_i;
        end
        [cmsf_pkg::CFG_MULT_ROW0 : cmsf_pkg::CFG_MULT_ROW3]: begin
          mult_q[moff] <= cfg_data_i[cmsf_pkg::MULT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = f_in_ready && !clear_busy;

  cmsf_hash #(
    .NUM_ROWS  (NUM_ROWS),
    .ROW_DEPTH (ROW_DEPTH),
    .IDX_W     (IDX_W)
  ) u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid && !clear_busy),
    .in_ready_o  (f_in_ready),
    .in_key_i    (s_axis_tdata[cmsf_pkg::KEY_W-1:0]),
    .mult_i      (mult_q),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_key_o   (f_key),
    .out_idx_o   (f_idx)
  );

  cmsf_queue #(
    .WIDTH (Q_W),
    .DEPTH (cmsf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .ready_o (f_ready),
    .data_i  ({f_idx, f_key}),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_data)
  );

  cmsf_count #(
    .NUM_ROWS   (NUM_ROWS),
    .ROW_DEPTH  (ROW_DEPTH),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_count (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .threshold_i  (thr_q),
    .q_valid_i    (q_valid),
    .q_key_i      (q_data[cmsf_pkg::KEY_W-1:0]),
    .q_idx_i      (q_data[Q_W-1:cmsf_pkg::KEY_W]),
    .q_pop_o      (q_pop),
    .clear_busy_o (clear_busy),
    .res_valid_o  (res_valid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = res;

endmodule
